>>> rtl/ecgbr_pkg.sv
`timescale 1ns / 1ps

package ecgbr_pkg;

  // Field and datapath widths.
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned STAMP_W = 17;
  localparam int unsigned INTV_W  = STAMP_W + 1;
  localparam int unsigned QUOT_W  = 16;
  localparam int unsigned RATE_W  = 8;
  localparam int unsigned CNT_W   = $clog2(QUOT_W);
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  // Number of stamp slots checked for a repeated or stepped-back stamp.
  localparam int unsigned SLOT_CNT = 4;
  localparam logic [INTV_W-1:0] SLOT_MS = INTV_W'(8);

  // Dividend of the rate division: milliseconds in one minute.
  localparam logic [QUOT_W-1:0] MS_PER_MINUTE = QUOT_W'(60000);

  // Register reset values.
  localparam logic [15:0] PEAK_THRESHOLD_RST = 16'd700;
  localparam logic [15:0] REFRACTORY_RST     = 16'd300;
  localparam logic [15:0] WRAP_PERIOD_RST    = 16'd60000;
  localparam logic [7:0]  RATE_FLOOR_RST     = 8'd30;
  localparam logic [7:0]  RATE_CAP_RST       = 8'd200;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_THRESHOLD = 8'd0,
    REG_REFRACTORY     = 8'd1,
    REG_WRAP_PERIOD    = 8'd2,
    REG_RATE_FLOOR     = 8'd3,
    REG_RATE_CAP       = 8'd4
  } cfg_reg_e;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } ecgbr_state_e;

  // Status returned by the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/ecgbr_div.sv
`timescale 1ns / 1ps

module ecgbr_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ecgbr_pkg::STAMP_W-1:0]       divisor_i,
  output ecgbr_pkg::div_stat_t                stat_o,
  output logic [ecgbr_pkg::QUOT_W-1:0]        quotient_o
);

  logic [ecgbr_pkg::STAMP_W-1:0] rem_q, rem_d;
  logic [ecgbr_pkg::STAMP_W-1:0] div_q;
  logic [ecgbr_pkg::QUOT_W-1:0]  quo_q, quo_d;
  logic [ecgbr_pkg::CNT_W-1:0]   cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [ecgbr_pkg::INTV_W-1:0]  trial;
  logic [ecgbr_pkg::INTV_W-1:0]  diff;
  logic                          fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_q, quo_q[ecgbr_pkg::QUOT_W-1]};
    diff  = trial - {1'b0, div_q};
    fits  = (trial >= {1'b0, div_q});
    rem_d = fits ? diff[ecgbr_pkg::STAMP_W-1:0] : trial[ecgbr_pkg::STAMP_W-1:0];
    quo_d = {quo_q[ecgbr_pkg::QUOT_W-2:0], fits};
  end

  // Control: one step per quotient bit, one quotient bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ecgbr_pkg::CNT_W'(ecgbr_pkg::QUOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the quotient register as quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= ecgbr_pkg::MS_PER_MINUTE;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

>>> rtl/ecg_beat_rate_detector_top.sv
`timescale 1ns / 1ps

// ECG beat and heart-rate detector.
// The input channel (in_valid_i / in_ready_o) carries one three-word sensor
// packet per beat. The output channel (out_valid_o / out_ready_i) returns one
// result per packet: the corrected stamp, the passed-through sensor fields,
// the current heart rate and a beat flag. The configuration channel
// (cfg_valid_i / cfg_ready_o) writes one register per beat and is always ready;
// write only while no packet is in flight. Unknown indexes are ignored.
// A result is loaded once its packet has passed the calculation step and,
// when the packet is a rate-producing beat, a division: the rate comes from a
// restoring divider that produces one quotient bit per cycle. One packet is in
// the engine at a time and the next can be accepted in the cycle after the
// result is loaded. A stalled receiver holds one finished result in the output
// register while one more packet is processed behind it; the input then stalls
// until the receiver takes the result.
// Reset loads the register defaults and clears the stamp history, the beat
// history and the rate; no output is valid after reset.
module ecg_beat_rate_detector_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Packet input.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ecgbr_pkg::WORD_W-1:0]      packet_word0_i,
  input  logic [ecgbr_pkg::WORD_W-1:0]      packet_word1_i,
  input  logic [ecgbr_pkg::WORD_W-1:0]      packet_word2_i,
  // Result output.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ecgbr_pkg::STAMP_W-1:0]     stamp_corrected_o,
  output logic [ecgbr_pkg::HALF_W-1:0]      ecg_value_o,
  output logic [ecgbr_pkg::HALF_W-1:0]      temperature_centi_o,
  output logic signed [ecgbr_pkg::HALF_W-1:0] accel_x_centi_o,
  output logic signed [ecgbr_pkg::HALF_W-1:0] accel_y_centi_o,
  output logic signed [ecgbr_pkg::HALF_W-1:0] accel_z_centi_o,
  output logic [ecgbr_pkg::RATE_W-1:0]      heart_rate_bpm_o,
  output logic                              beat_detected_o,
  // Configuration writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ecgbr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ecgbr_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  ecgbr_pkg::ecgbr_state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] peak_threshold_q;
  logic [15:0] refractory_q;
  logic [15:0] wrap_period_q;
  logic [7:0]  rate_floor_q;
  logic [7:0]  rate_cap_q;

  // Detector history.
  logic [ecgbr_pkg::STAMP_W-1:0] prev_stamp_q;
  logic [ecgbr_pkg::STAMP_W-1:0] last_beat_q;
  logic                          beat_seen_q;
  logic [ecgbr_pkg::RATE_W-1:0]  rate_q;

  // Packet held in the engine.
  logic [ecgbr_pkg::WORD_W-1:0]  w0_q, w1_q, w2_q;
  logic [ecgbr_pkg::STAMP_W-1:0] stamp_q;
  logic                          beat_q;

  // Output register.
  logic                          out_valid_q;
  logic [ecgbr_pkg::STAMP_W-1:0] out_stamp_q;
  logic [ecgbr_pkg::HALF_W-1:0]  out_ecg_q, out_temp_q, out_ax_q, out_ay_q, out_az_q;
  logic [ecgbr_pkg::RATE_W-1:0]  out_rate_q;
  logic                          out_beat_q;

  // Stamp correction and beat decision.
  logic [ecgbr_pkg::STAMP_W-1:0] raw;
  logic [ecgbr_pkg::STAMP_W-1:0] stamp_fix;
  logic                          slot_hit;
  logic signed [ecgbr_pkg::INTV_W-1:0] intv_raw, intv, refr_s;
  logic                          beat;

  // Sequencer controls.
  logic                          accept;
  logic                          calc_en;
  logic                          div_start;
  logic                          rate_en;
  logic                          out_load;

  // Divider.
  ecgbr_pkg::div_stat_t          div_stat;
  logic [ecgbr_pkg::QUOT_W-1:0]  quotient;
  logic [ecgbr_pkg::STAMP_W-1:0] div_divisor;

  assign cfg_ready_o = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_threshold_q <= ecgbr_pkg::PEAK_THRESHOLD_RST;
      refractory_q     <= ecgbr_pkg::REFRACTORY_RST;
      wrap_period_q    <= ecgbr_pkg::WRAP_PERIOD_RST;
      rate_floor_q     <= ecgbr_pkg::RATE_FLOOR_RST;
      rate_cap_q       <= ecgbr_pkg::RATE_CAP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ecgbr_pkg::REG_PEAK_THRESHOLD: peak_threshold_q <= cfg_data_i;
        ecgbr_pkg::REG_REFRACTORY:     refractory_q     <= cfg_data_i;
        ecgbr_pkg::REG_WRAP_PERIOD:    wrap_period_q    <= cfg_data_i;
        ecgbr_pkg::REG_RATE_FLOOR:     rate_floor_q     <= cfg_data_i[7:0];
        ecgbr_pkg::REG_RATE_CAP:       rate_cap_q       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // A stamp equal to the previous one, or up to three slots behind it, is
  // pushed forward to one slot past the previous stamp.
  always_comb begin
    raw       = {1'b0, w0_q[ecgbr_pkg::WORD_W-1:ecgbr_pkg::HALF_W]};
    stamp_fix = raw;
    slot_hit  = 1'b0;
    for (int k = 0; k < ecgbr_pkg::SLOT_CNT; k++) begin
      if (!slot_hit &&
          ({1'b0, raw} + ecgbr_pkg::SLOT_MS * ecgbr_pkg::INTV_W'(k)) == {1'b0, prev_stamp_q}) begin
        slot_hit  = 1'b1;
        stamp_fix = ecgbr_pkg::STAMP_W'({1'b0, raw} + ecgbr_pkg::SLOT_MS * ecgbr_pkg::INTV_W'(k + 1));
      end
    end
  end

  // Interval since the last beat, wrapped by the stamp period.
  always_comb begin
    refr_s = $signed({2'b00, refractory_q});
    if (beat_seen_q) begin
      intv_raw = $signed({1'b0, stamp_fix}) - $signed({1'b0, last_beat_q});
    end else begin
      intv_raw = $signed({1'b0, stamp_fix}) + ecgbr_pkg::INTV_W'(1);
    end
    if (intv_raw < -refr_s) begin
      intv = intv_raw + $signed({2'b00, wrap_period_q});
    end else begin
      intv = intv_raw;
    end
    beat = (w0_q[ecgbr_pkg::HALF_W-1:0] > peak_threshold_q) && (intv > refr_s);
  end

  assign div_divisor = intv[ecgbr_pkg::STAMP_W-1:0];
  assign in_ready_o  = (state_q == ecgbr_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ecgbr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and sequencer controls.
  always_comb begin
    state_d   = state_q;
    calc_en   = 1'b0;
    div_start = 1'b0;
    rate_en   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ecgbr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ecgbr_pkg::ST_CALC;
        end
      end
      ecgbr_pkg::ST_CALC: begin
        calc_en = 1'b1;
        if (beat && beat_seen_q) begin
          div_start = 1'b1;
          state_d   = ecgbr_pkg::ST_DIV;
        end else begin
          state_d = ecgbr_pkg::ST_DONE;
        end
      end
      ecgbr_pkg::ST_DIV: begin
        if (div_stat.done) begin
          rate_en = 1'b1;
          state_d = ecgbr_pkg::ST_DONE;
        end
      end
      ecgbr_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ecgbr_pkg::ST_IDLE;
        end
      end
      default: state_d = ecgbr_pkg::ST_IDLE;
    endcase
  end

  // History: updated once per packet, the rate only after a division.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_stamp_q <= '0;
      last_beat_q  <= '0;
      beat_seen_q  <= 1'b0;
      rate_q       <= '0;
    end else begin
      if (calc_en) begin
        prev_stamp_q <= stamp_fix;
        if (beat) begin
          last_beat_q <= stamp_fix;
          beat_seen_q <= 1'b1;
        end
      end
      if (rate_en) begin
        if (quotient < {8'd0, rate_floor_q}) begin
          rate_q <= '0;
        end else if (quotient <= {8'd0, rate_cap_q}) begin
          rate_q <= quotient[ecgbr_pkg::RATE_W-1:0];
        end
      end
    end
  end

  // Packet capture and per-packet results.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      w0_q <= packet_word0_i;
      w1_q <= packet_word1_i;
      w2_q <= packet_word2_i;
    end
    if (calc_en) begin
      stamp_q <= stamp_fix;
      beat_q  <= beat;
    end
  end

  ecgbr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Output register: holds one finished result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_stamp_q <= stamp_q;
      out_ecg_q   <= w0_q[ecgbr_pkg::HALF_W-1:0];
      out_temp_q  <= w1_q[ecgbr_pkg::WORD_W-1:ecgbr_pkg::HALF_W];
      out_ax_q    <= w1_q[ecgbr_pkg::HALF_W-1:0];
      out_ay_q    <= w2_q[ecgbr_pkg::WORD_W-1:ecgbr_pkg::HALF_W];
      out_az_q    <= w2_q[ecgbr_pkg::HALF_W-1:0];
      out_rate_q  <= rate_q;
      out_beat_q  <= beat_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign stamp_corrected_o   = out_stamp_q;
  assign ecg_value_o         = out_ecg_q;
  assign temperature_centi_o = out_temp_q;
  assign accel_x_centi_o     = $signed(out_ax_q);
  assign accel_y_centi_o     = $signed(out_ay_q);
  assign accel_z_centi_o     = $signed(out_az_q);
  assign heart_rate_bpm_o    = out_rate_q;
  assign beat_detected_o     = out_beat_q;

  // An accepted packet always moves straight into the calculation step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ecgbr_pkg::ST_CALC)
    else $error("accepted packet did not enter calculation");

  // A division is only started with a nonzero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_divisor != '0)
    else $error("divider started with zero divisor");

  // While waiting on the divider it must be working or finishing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ecgbr_pkg::ST_DIV |-> div_stat.busy || div_stat.done)
    else $error("waiting on an idle divider");

  // A reported beat implies the beat history has been set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && beat_detected_o |-> beat_seen_q)
    else $error("beat reported without beat history");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import ecgbr_pkg::*;

  // Register indexes that no register answers to.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = {CFG_IDX_W{1'b1}};

  // One result as the block reports it.
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [HALF_W-1:0]  ecg;
    logic [HALF_W-1:0]  temp;
    logic [HALF_W-1:0]  accel_x;
    logic [HALF_W-1:0]  accel_y;
    logic [HALF_W-1:0]  accel_z;
    logic [RATE_W-1:0]  rate;
    logic               beat;
  } sensor_reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready_o;
  logic [WORD_W-1:0]    packet_word0 = '0;
  logic [WORD_W-1:0]    packet_word1 = '0;
  logic [WORD_W-1:0]    packet_word2 = '0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  logic [STAMP_W-1:0]   stamp_corrected_o;
  logic [HALF_W-1:0]    ecg_value_o;
  logic [HALF_W-1:0]    temperature_centi_o;
  logic signed [HALF_W-1:0] accel_x_centi_o;
  logic signed [HALF_W-1:0] accel_y_centi_o;
  logic signed [HALF_W-1:0] accel_z_centi_o;
  logic [RATE_W-1:0]    heart_rate_bpm_o;
  logic                 beat_detected_o;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // Idle percentages of both sides and the long receiver hold-off.
  int  tx_idle_pct = 15;
  int  rx_idle_pct = 56;
  logic rx_stall = 1'b0;

  // Predicted register contents and detector history.
  logic [15:0]        exp_peak_thr   = PEAK_THRESHOLD_RST;
  logic [15:0]        exp_refractory = REFRACTORY_RST;
  logic [15:0]        exp_wrap       = WRAP_PERIOD_RST;
  logic [7:0]         exp_rate_lo    = RATE_FLOOR_RST;
  logic [7:0]         exp_rate_hi    = RATE_CAP_RST;
  logic [STAMP_W-1:0] exp_prev_stamp = '0;
  logic [STAMP_W-1:0] exp_last_beat  = '0;
  logic               exp_beat_seen  = 1'b0;
  logic [RATE_W-1:0]  exp_rate       = '0;

  sensor_reading_t expected_readings_q[$];
  int mismatch_cnt = 0;
  int sensor_ms = 0;

  ecg_beat_rate_detector_top i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .packet_word0_i      (packet_word0),
    .packet_word1_i      (packet_word1),
    .packet_word2_i      (packet_word2),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .stamp_corrected_o   (stamp_corrected_o),
    .ecg_value_o         (ecg_value_o),
    .temperature_centi_o (temperature_centi_o),
    .accel_x_centi_o     (accel_x_centi_o),
    .accel_y_centi_o     (accel_y_centi_o),
    .accel_z_centi_o     (accel_z_centi_o),
    .heart_rate_bpm_o    (heart_rate_bpm_o),
    .beat_detected_o     (beat_detected_o),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a run that hangs.
  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Predict the result of one packet and advance the detector history.
  task automatic predict_reading(input logic [WORD_W-1:0] w0, w1, w2);
    sensor_reading_t    r;
    logic [15:0]        raw;
    logic [STAMP_W-1:0] stamp;
    logic               fixed;
    logic               beat;
    int                 k;
    int                 interval;
    int                 quo;
    raw = w0[31:16];
    stamp = STAMP_W'(raw);
    fixed = 1'b0;
    beat = 1'b0;
    // A repeated or stepped-back stamp moves forward to one slot past the previous one.
    for (k = 0; k < 4; k++) begin
      if (!fixed && int'(raw) == int'(exp_prev_stamp) - 8 * k) begin
        stamp = STAMP_W'(int'(raw) + 8 * (k + 1));
        fixed = 1'b1;
      end
    end
    exp_prev_stamp = stamp;
    interval = exp_beat_seen ? int'(stamp) - int'(exp_last_beat) : int'(stamp) + 1;
    if (interval < -int'(exp_refractory))
      interval += int'(exp_wrap);
    if (w0[15:0] > exp_peak_thr && interval > int'(exp_refractory)) begin
      beat = 1'b1;
      if (exp_beat_seen) begin
        quo = 60000 / interval;
        if (quo < int'(exp_rate_lo))
          exp_rate = '0;
        else if (quo <= int'(exp_rate_hi))
          exp_rate = RATE_W'(quo);
      end
      exp_beat_seen = 1'b1;
      exp_last_beat = stamp;
    end
    r.stamp   = stamp;
    r.ecg     = w0[15:0];
    r.temp    = w1[31:16];
    r.accel_x = w1[15:0];
    r.accel_y = w2[31:16];
    r.accel_z = w2[15:0];
    r.rate    = exp_rate;
    r.beat    = beat;
    expected_readings_q.push_back(r);
  endtask

  // Offer one packet beat, with a random gap ahead of it.
  task automatic send_packet(input logic [WORD_W-1:0] w0, w1, w2);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    packet_word0 <= w0;
    packet_word1 <= w1;
    packet_word2 <= w2;
    do @(posedge clk); while (!in_ready_o);
    predict_reading(w0, w1, w2);
  endtask

  task automatic end_packet_stream();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every predicted result has been returned.
  task automatic wait_drain();
    while (expected_readings_q.size() != 0)
      @(negedge clk);
  endtask

  // Write one register beat and mirror it into the prediction.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      REG_PEAK_THRESHOLD: exp_peak_thr   = data;
      REG_REFRACTORY:     exp_refractory = data;
      REG_WRAP_PERIOD:    exp_wrap       = data;
      REG_RATE_FLOOR:     exp_rate_lo    = data[7:0];
      REG_RATE_CAP:       exp_rate_hi    = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_registers(input logic [15:0] thr, refr, wrap, lo, hi);
    write_register(REG_PEAK_THRESHOLD, thr);
    write_register(REG_REFRACTORY, refr);
    write_register(REG_WRAP_PERIOD, wrap);
    write_register(REG_RATE_FLOOR, lo);
    write_register(REG_RATE_CAP, hi);
  endtask

  // Random sensor traffic: mostly a stamp that runs forward with peaks on
  // top of a quiet trace, some repeated or stepped-back stamps, some noise.
  task automatic send_sensor_stream(input int count);
    int               n;
    int               kind;
    int               step;
    int               back;
    logic [15:0]      raw;
    logic [15:0]      ecg;
    logic [WORD_W-1:0] w0;
    for (n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: step = 8;
        6, 7, 8:          step = $urandom_range(1, 400);
        default:          step = $urandom_range(400, 3000);
      endcase
      sensor_ms = (sensor_ms + step) % int'(exp_wrap);
      raw = 16'(sensor_ms);
      if (kind < 12) begin
        back = int'(exp_prev_stamp) - 8 * $urandom_range(0, 3);
        if (back >= 0 && back <= 65535)
          raw = 16'(back);
      end
      if ($urandom_range(0, 99) < 30 && exp_peak_thr != 16'hFFFF)
        ecg = 16'($urandom_range(int'(exp_peak_thr) + 1, 65535));
      else
        ecg = 16'($urandom_range(0, int'(exp_peak_thr)));
      w0 = (kind >= 88) ? $urandom() : {raw, ecg};
      send_packet(w0, $urandom(), $urandom());
    end
  endtask

  // Stamp corrections, refractory and floor boundaries, wrap, field extremes.
  task automatic test_default_sequence();
    send_packet({16'd0, 16'd0}, 32'h0000_0000, 32'h0000_0000);
    send_packet({16'd0, 16'd0}, $urandom(), $urandom());
    send_packet({16'd0, 16'd0}, $urandom(), $urandom());
    send_packet({16'd0, 16'd0}, $urandom(), $urandom());
    send_packet({16'd0, 16'd0}, $urandom(), $urandom());
    send_packet({16'd400, 16'd700}, 32'hFFFF_8000, 32'h7FFF_FFFF);
    send_packet({16'd400, 16'd701}, 32'h0000_7FFF, 32'h8000_0000);
    send_packet({16'd708, 16'hFFFF}, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_packet({16'd709, 16'hFFFF}, $urandom(), $urandom());
    send_packet({16'd2710, 16'd1000}, $urandom(), $urandom());
    send_packet({16'd4710, 16'd1000}, $urandom(), $urandom());
    send_packet({16'd59900, 16'd5000}, $urandom(), $urandom());
    send_packet({16'd400, 16'd5000}, $urandom(), $urandom());
    send_packet({16'd100, 16'd5000}, $urandom(), $urandom());
    send_packet({16'd99, 16'd5000}, $urandom(), $urandom());
    send_packet({16'hFFFF, 16'd0}, $urandom(), $urandom());
    send_packet({16'hFFFF, 16'd0}, $urandom(), $urandom());
    send_packet({16'hFFFF, 16'hFFFF}, $urandom(), $urandom());
    end_packet_stream();
    wait_drain();
  endtask

  // Register extremes, ignored upper data bits, unused indexes and a floor
  // that sits above the cap.
  task automatic test_register_extremes();
    program_registers(16'h0000, 16'h0000, 16'h0001, 16'hA5FF, 16'h5A00);
    write_register(REG_UNUSED_FIRST, 16'hFFFF);
    write_register(REG_UNUSED_LAST, 16'hFFFF);
    send_sensor_stream(10);
    end_packet_stream();
    wait_drain();
    program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h00FF);
    send_sensor_stream(8);
    end_packet_stream();
    wait_drain();
    program_registers(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h00FF);
    send_sensor_stream(10);
    end_packet_stream();
    wait_drain();
    program_registers(16'd500, 16'd100, 16'd60000, 16'd200, 16'd100);
    send_sensor_stream(12);
    end_packet_stream();
    wait_drain();
  endtask

  // Slow receiver, with one long hold-off and one drained pause.
  task automatic test_stream_receiver_slow();
    tx_idle_pct = 15;
    rx_idle_pct = 56;
    program_registers(PEAK_THRESHOLD_RST, REFRACTORY_RST, WRAP_PERIOD_RST,
                      16'(RATE_FLOOR_RST), 16'(RATE_CAP_RST));
    send_sensor_stream(150);
    // Hold the receiver off so the block fills and stalls its input.
    fork
      begin
        @(posedge clk);
        rx_stall <= 1'b1;
        repeat (300) @(posedge clk);
        rx_stall <= 1'b0;
      end
    join_none
    send_sensor_stream(20);
    // Pause the sender until every result is back.
    end_packet_stream();
    wait_drain();
    send_sensor_stream(150);
    end_packet_stream();
    wait_drain();
  endtask

  task automatic test_stream_sender_slow();
    tx_idle_pct = 56;
    rx_idle_pct = 15;
    program_registers(16'($urandom_range(0, 4000)), 16'($urandom_range(150, 600)),
                      16'($urandom_range(20000, 65535)), 16'($urandom_range(20, 60)),
                      16'($urandom_range(120, 250)));
    send_sensor_stream(320);
    end_packet_stream();
    wait_drain();
  endtask

  task automatic test_stream_full_rate();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_registers(16'($urandom_range(0, 4000)), 16'($urandom_range(150, 600)),
                      16'($urandom_range(20000, 65535)), 16'($urandom_range(20, 60)),
                      16'($urandom_range(120, 250)));
    send_sensor_stream(310);
    end_packet_stream();
    wait_drain();
  endtask

  // Receiver ready, idling at random or held off.
  always @(negedge clk) begin
    if (rx_stall)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Compare each returned result with the oldest prediction.
  always @(posedge clk) begin : check_results
    sensor_reading_t got;
    sensor_reading_t want;
    logic            bad;
    if (rst_n && out_valid_o && out_ready) begin
      got = '{stamp_corrected_o, ecg_value_o, temperature_centi_o, accel_x_centi_o,
              accel_y_centi_o, accel_z_centi_o, heart_rate_bpm_o, beat_detected_o};
      if (expected_readings_q.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected result: stamp %0d ecg %0d", got.stamp, got.ecg);
        mismatch_cnt++;
      end else begin
        want = expected_readings_q.pop_front();
        bad = (got.stamp !== want.stamp) || (got.ecg !== want.ecg) ||
              (got.temp !== want.temp) || (got.accel_x !== want.accel_x) ||
              (got.accel_y !== want.accel_y) || (got.accel_z !== want.accel_z) ||
              (got.rate !== want.rate) || (got.beat !== want.beat);
        if (bad) begin
          if (mismatch_cnt < 10)
            $display("mismatch (exp/act): stamp %0d/%0d ecg %0d/%0d temp %0d/%0d",
                     want.stamp, got.stamp, want.ecg, got.ecg, want.temp, got.temp,
                     " ax %0d/%0d ay %0d/%0d az %0d/%0d rate %0d/%0d beat %0d/%0d",
                     $signed(want.accel_x), $signed(got.accel_x),
                     $signed(want.accel_y), $signed(got.accel_y),
                     $signed(want.accel_z), $signed(got.accel_z),
                     want.rate, got.rate, want.beat, got.beat);
          mismatch_cnt++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_default_sequence();
    test_register_extremes();
    test_stream_receiver_slow();
    test_stream_sender_slow();
    test_stream_full_rate();
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && expected_readings_q.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

>>> sim.f
rtl/ecgbr_pkg.sv
rtl/ecgbr_div.sv
rtl/ecg_beat_rate_detector_top.sv
tb/tb.sv
